@@ design/tdpt_pkg.sv @@
// Shared types and constants for the trial-division prime test.
// Used by the front, queue, back and top-level modules; depends on nothing.

package tdpt_pkg;

	// Smallest odd trial divisor and the only even prime
	localparam int FIRST_DIVISOR = 3;
	localparam int EVEN_PRIME    = 2;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Classification made by the front end
	typedef enum logic [1:0] {
		CLS_NOT_PRIME,
		CLS_PRIME,
		CLS_TRIAL
	} cls_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CHECK,
		BK_DIV
	} bk_state_t;

	// Handshake between a producer and a queue
	typedef struct packed {
		logic push;
		logic full;
	} push_hs_t;

endpackage

@@ design/tdpt_front.sv @@
// Front end: takes candidates and sorts them into trivial and trial-division cases.
// Depends on tdpt_pkg for the class type and constants.

module tdpt_front #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [NUMBER_WIDTH-1:0]   candidate,
	output tdpt_pkg::push_hs_t        q_hs_o,
	input  logic                      q_full,
	output logic [NUMBER_WIDTH-1:0]   q_value,
	output tdpt_pkg::cls_t            q_cls
);

	logic                    vld_s1;
	logic [NUMBER_WIDTH-1:0] val_s1;
	tdpt_pkg::cls_t          cls_s1;
	tdpt_pkg::cls_t          cls_d;
	logic                    take;

	// Classify by sign, size and parity
	always_comb begin
		if (candidate[NUMBER_WIDTH-1] || candidate[NUMBER_WIDTH-1:1] == '0) begin
			cls_d = tdpt_pkg::CLS_NOT_PRIME;
		end else if (candidate == NUMBER_WIDTH'(tdpt_pkg::EVEN_PRIME)) begin
			cls_d = tdpt_pkg::CLS_PRIME;
		end else if (!candidate[0]) begin
			cls_d = tdpt_pkg::CLS_NOT_PRIME;
		end else begin
			cls_d = tdpt_pkg::CLS_TRIAL;
		end
	end

	// Stall only while the stage holds a beat the queue cannot take
	assign full = vld_s1 && q_full;
	assign take = push && !full;

	// Hold the classified beat until the queue accepts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!full) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			val_s1 <= candidate;
			cls_s1 <= cls_d;
		end
	end

	assign q_hs_o.push = vld_s1 && !q_full;
	assign q_hs_o.full = q_full;
	assign q_value     = val_s1;
	assign q_cls       = cls_s1;

endmodule

@@ design/tdpt_queue.sv @@
// Short register queue between front and back ends.
// Depends on tdpt_pkg for the push handshake struct.

module tdpt_queue #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tdpt_pkg::push_hs_t   hs_i,
	output logic                 q_full,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic                 pop,
	output logic                 empty,
	output logic [WIDTH-1:0]     rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign q_full  = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = hs_i.push && !q_full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef ASSERT_OFF
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		hs_i.push |-> !hs_i.full)
		else $error("queue pushed while full");
`endif

endmodule

@@ design/tdpt_back.sv @@
// Back end: runs trial division with a bit-serial remainder unit and holds the result.
// Depends on tdpt_pkg for class and state types and constants.

module tdpt_back #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	output logic                    q_pop,
	input  logic [NUMBER_WIDTH-1:0] q_value,
	input  tdpt_pkg::cls_t          q_cls,
	input  logic                    pop,
	output logic                    empty,
	output logic [NUMBER_WIDTH-1:0] tested_value,
	output logic                    is_prime
);

	localparam int DW = NUMBER_WIDTH / 2 + 1;   // divisor width
	localparam int SW = NUMBER_WIDTH + 1;       // divisor-squared width
	localparam int CW = $clog2(NUMBER_WIDTH);   // bit counter width

	tdpt_pkg::bk_state_t     state_q;
	tdpt_pkg::bk_state_t     state_d;
	logic [NUMBER_WIDTH-1:0] n_q;
	logic [DW-1:0]           d_q;
	logic [SW-1:0]           sq_q;
	logic [DW-1:0]           rem_q;
	logic [CW-1:0]           cnt_q;
	logic                    res_valid_q;
	logic [NUMBER_WIDTH-1:0] res_value_q;
	logic                    res_prime_q;
	logic                    slot_free;
	logic                    res_wr;
	logic                    res_prime;
	logic [DW:0]             rem_sh;
	logic [DW:0]             rem_sub;
	logic [DW-1:0]           rem_next;

	assign slot_free = !res_valid_q || pop;

	// One restoring-division step: shift in the next dividend bit
	assign rem_sh   = {rem_q, n_q[cnt_q]};
	assign rem_sub  = rem_sh - {1'b0, d_q};
	assign rem_next = (rem_sh >= {1'b0, d_q}) ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

	// Sequence: fetch, check bound, divide
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		res_wr    = 1'b0;
		res_prime = 1'b0;
		case (state_q)
			tdpt_pkg::BK_IDLE: begin
				if (!q_empty && slot_free) begin
					q_pop = 1'b1;
					if (q_cls == tdpt_pkg::CLS_TRIAL) begin
						state_d = tdpt_pkg::BK_CHECK;
					end else begin
						res_wr    = 1'b1;
						res_prime = q_cls == tdpt_pkg::CLS_PRIME;
					end
				end
			end
			tdpt_pkg::BK_CHECK: begin
				if (sq_q > {1'b0, n_q}) begin
					res_wr    = 1'b1;
					res_prime = 1'b1;
					state_d   = tdpt_pkg::BK_IDLE;
				end else begin
					state_d = tdpt_pkg::BK_DIV;
				end
			end
			tdpt_pkg::BK_DIV: begin
				if (cnt_q == '0) begin
					if (rem_next == '0) begin
						res_wr  = 1'b1;
						state_d = tdpt_pkg::BK_IDLE;
					end else begin
						state_d = tdpt_pkg::BK_CHECK;
					end
				end
			end
			default: begin
				state_d = tdpt_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpt_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Divisor, square and remainder datapath
	always_ff @(posedge clk) begin
		case (state_q)
			tdpt_pkg::BK_IDLE: begin
				n_q  <= q_value;
				d_q  <= DW'(tdpt_pkg::FIRST_DIVISOR);
				sq_q <= SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
			end
			tdpt_pkg::BK_CHECK: begin
				rem_q <= '0;
				cnt_q <= CW'(NUMBER_WIDTH - 1);
			end
			tdpt_pkg::BK_DIV: begin
				rem_q <= rem_next;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					// (d + 2)^2 = d^2 + 4d + 4
					d_q  <= d_q + DW'(2);
					sq_q <= sq_q + SW'({d_q, 2'b00}) + SW'(4);
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// Result slot: fill on completion, drop on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_wr) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_value_q <= (state_q == tdpt_pkg::BK_IDLE) ? q_value : n_q;
			res_prime_q <= res_prime;
		end
	end

	assign empty        = !res_valid_q;
	assign tested_value = res_value_q;
	assign is_prime     = res_prime_q;

`ifndef ASSERT_OFF
	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdpt_pkg::BK_CHECK || state_q == tdpt_pkg::BK_DIV) |-> d_q[0])
		else $error("trial divisor is even");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdpt_pkg::BK_DIV) |-> (rem_q < d_q))
		else $error("partial remainder not below divisor");
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> slot_free)
		else $error("result overwritten before delivery");
	a_busy_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdpt_pkg::BK_CHECK) |-> !res_valid_q)
		else $error("test running with a result still waiting");
`endif

endmodule

@@ design/trial_division_prime_test.sv @@
// Top level of the trial-division prime test: front end, queue and back end.
// Depends on tdpt_pkg, tdpt_front, tdpt_queue and tdpt_back.
//
// Usage:
//   Input channel: drive candidate and raise push; the beat is taken on a
//   rising edge with push high and full low.
//   Result channel: while empty is low, tested_value and is_prime show the
//   oldest result; it is taken on a rising edge with pop high.
//   Flow: negative, zero, one, two and even numbers pass through the front
//   stage and the queue and go to the result slot without trial division.
//   An odd number n >= 3 is tried against odd divisors d while d*d <= n;
//   each divisor takes one bound check, then a one-bit-per-cycle
//   remainder.
//   Throughput: one test at a time, set by the bit-serial remainder unit;
//   the front stage and a two-entry queue keep accepting up to three more
//   beats while a test runs.
//   Reset: arst_n low empties the queue and result slot and idles the
//   sequencer. A stalled receiver holds the result in place; the back end
//   waits for the slot before starting the next item, and full rises once
//   the queue and front stage are occupied.

module trial_division_prime_test #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [NUMBER_WIDTH-1:0] candidate,
	output logic                    empty,
	input  logic                    pop,
	output logic [NUMBER_WIDTH-1:0] tested_value,
	output logic                    is_prime
);

	localparam int CLS_W = $bits(tdpt_pkg::cls_t);
	localparam int QW    = NUMBER_WIDTH + CLS_W;

	tdpt_pkg::push_hs_t      q_hs;
	logic                    q_full;
	logic [NUMBER_WIDTH-1:0] f_value;
	tdpt_pkg::cls_t          f_cls;
	logic [QW-1:0]           q_rd_data;
	logic                    q_empty;
	logic                    q_pop;

	tdpt_front #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.candidate (candidate),
		.q_hs_o    (q_hs),
		.q_full    (q_full),
		.q_value   (f_value),
		.q_cls     (f_cls)
	);

	tdpt_queue #(
		.WIDTH(QW),
		.DEPTH(tdpt_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.hs_i    (q_hs),
		.q_full  (q_full),
		.wr_data ({f_value, f_cls}),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_data (q_rd_data)
	);

	tdpt_back #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_value      (q_rd_data[QW-1:CLS_W]),
		.q_cls        (tdpt_pkg::cls_t'(q_rd_data[CLS_W-1:0])),
		.pop          (pop),
		.empty        (empty),
		.tested_value (tested_value),
		.is_prime     (is_prime)
	);

endmodule

@@ tb/sv/tb_trial_division_prime_test.sv @@
// Self-checking testbench for trial_division_prime_test: directed and random candidates.
// Holds its own primality predictor and a verdict scoreboard; depends on tdpt_pkg and the RTL.

module tb_trial_division_prime_test;

	localparam int NUMBER_WIDTH     = 32;
	localparam int STALL_LIMIT      = 3_000_000;
	localparam int MAX_REPORTED     = 10;
	localparam int RANDOM_PER_PHASE = 25;
	localparam int SETTLE_CYCLES    = 20;
	localparam int RESET_CYCLES     = 10;

	typedef struct {
		logic [NUMBER_WIDTH-1:0] value;
		bit                      prime;
	} prime_verdict_t;

	// Verdict scoreboard: predict on every accepted candidate, check every popped result
	class verdict_board;
		prime_verdict_t awaiting[$];
		int             mismatches;
		int             noted;
		int             checked;
		int             primes_seen;

		function bit trial_verdict(logic [NUMBER_WIDTH-1:0] n);
			longint unsigned v;
			longint unsigned d;
			v = n;
			if (n[NUMBER_WIDTH-1] || v < tdpt_pkg::EVEN_PRIME)
				return 1'b0;
			if (v == tdpt_pkg::EVEN_PRIME)
				return 1'b1;
			if (!n[0])
				return 1'b0;
			for (d = tdpt_pkg::FIRST_DIVISOR; d <= v / d; d += 2)
				if (v % d == 0)
					return 1'b0;
			return 1'b1;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= MAX_REPORTED)
				$display("mismatch: %s", what);
		endfunction

		function void note_candidate(logic [NUMBER_WIDTH-1:0] n);
			prime_verdict_t entry;
			entry.value = n;
			entry.prime = trial_verdict(n);
			awaiting.push_back(entry);
			noted++;
		endfunction

		function void check_result(logic [NUMBER_WIDTH-1:0] tv, logic ip);
			prime_verdict_t entry;
			if (awaiting.size() == 0) begin
				flag($sformatf("result %0d/%b popped with nothing awaiting", $signed(tv), ip));
				return;
			end
			entry = awaiting.pop_front();
			checked++;
			if (entry.prime)
				primes_seen++;
			if (tv !== entry.value)
				flag($sformatf("tested_value expected %0d, got %0d",
					$signed(entry.value), $signed(tv)));
			if (ip !== entry.prime)
				flag($sformatf("is_prime for %0d expected %b, got %b",
					$signed(entry.value), entry.prime, ip));
		endfunction

		function int pending();
			return awaiting.size();
		endfunction
	endclass

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    push         = 1'b0;
	logic [NUMBER_WIDTH-1:0] candidate    = '0;
	logic                    pop          = 1'b0;
	logic                    full;
	logic                    empty;
	logic [NUMBER_WIDTH-1:0] tested_value;
	logic                    is_prime;

	int           send_idle_pct = 0;
	int           pop_stall_pct = 0;
	int           stall_count   = 0;
	int           directed_count;
	verdict_board board;

	trial_division_prime_test #(.NUMBER_WIDTH(NUMBER_WIDTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.candidate   (candidate),
		.empty       (empty),
		.pop         (pop),
		.tested_value(tested_value),
		.is_prime    (is_prime)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Drive one candidate beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [NUMBER_WIDTH-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push      = 1'b1;
		candidate = value;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.note_candidate(value);
		@(negedge clk);
		push = 1'b0;
	endtask

	// Hold the sender until every outstanding verdict has been popped
	task automatic drain_results();
		push = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	// Mostly small odd numbers so the serial divider stays quick; high bits come from
	// negatives, evens and odd multiples of a small factor
	function automatic logic [NUMBER_WIDTH-1:0] random_candidate();
		int unsigned factors[5] = '{3, 5, 7, 11, 13};
		int unsigned roots[8]   = '{3, 5, 7, 11, 13, 101, 251, 509};
		int unsigned pick;
		int unsigned f;
		int unsigned m;
		pick = $urandom_range(99);
		if (pick < 30)
			return $urandom_range(3, 4095) | 1;
		if (pick < 40)
			return $urandom_range(4097, 262143) | 1;
		if (pick < 55)
			return $urandom | 32'h8000_0000;
		if (pick < 70)
			return $urandom & 32'h7FFF_FFFE;
		if (pick < 78)
			return $urandom_range(0, 3);
		if (pick < 90) begin
			f = factors[$urandom_range(0, 4)];
			m = $urandom_range(0, (32'h7FFF_FFFF / f - 1) / 2) * 2 + 1;
			return f * m;
		end
		// Squares and twin products sit right on the divisor-squared bound
		f = roots[$urandom_range(0, 7)];
		return ($urandom_range(1) != 0) ? f * f : f * (f + 2);
	endfunction

	// Pop side: random stalls, check each popped beat at the rising edge
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pop = ($urandom_range(99) >= pop_stall_pct);
			@(posedge clk);
			if (pop && !empty)
				board.check_result(tested_value, is_prime);
		end
	end

	// Watchdog: abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [NUMBER_WIDTH-1:0] directed[$];
		int                      idle_plan[4];
		int                      stall_plan[4];

		board      = new();
		idle_plan  = '{0, 81, 0, 22};
		stall_plan = '{0, 0, 81, 22};
		// Field extremes, tiny values, exact squares, negatives, large evens and odds
		directed = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
			32'd97, 32'd121, 32'd65537, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE,
			32'hFFFF_FFFD, 32'hAAAA_AAAA, 32'h7FFF_FFFE, 32'h5555_5555, 32'h7FFF_FFFD,
			32'h7FFF_FFFF
		};
		directed_count = directed.size();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_beat(directed[i]);
		drain_results();

		// Random phases: no idling, sender idle, receiver stalling, both
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_plan[p];
			pop_stall_pct = stall_plan[p];
			repeat (RANDOM_PER_PHASE)
				send_beat(random_candidate());
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Tested %0d candidates (%0d directed, rest random over four idle/stall mixes).",
			board.noted, directed_count);
		$display("Checked %0d verdicts, %0d prime, %0d mismatches.",
			board.checked, board.primes_seen, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ trial_division_prime_test.f @@
design/tdpt_pkg.sv
design/tdpt_front.sv
design/tdpt_queue.sv
design/tdpt_back.sv
design/trial_division_prime_test.sv
tb/sv/tb_trial_division_prime_test.sv
